@@ design/golomb_bitstream_decoder_top_assert.svh @@
// assertion helpers for the decoder top
`ifndef GOLOMB_BITSTREAM_DECODER_TOP_ASSERT_SVH
`define GOLOMB_BITSTREAM_DECODER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/gbd_pkg.sv @@
package gbd_pkg;

    localparam int BYTE_BITS         = 8;
    localparam int BYTE_CNT_BITS     = 4;
    localparam int VALUE_BITS        = 28;
    localparam int DIVISOR_REG_BITS  = 13;
    localparam int QUOTIENT_BITS_DEF = 16;
    localparam int DIVISOR_BITS_DEF  = 12;

    // one register write
    typedef struct packed {
        logic                        we;
        logic [DIVISOR_REG_BITS-1:0] data;
    } gbd_cfg_wr_t;

    // outcome of one decoded bit
    typedef struct packed {
        logic                  emit;
        logic                  sat;
        logic [VALUE_BITS-1:0] value;
    } gbd_result_t;

endpackage

@@ design/gbd_channels.sv @@
interface gbd_byte_if
    import gbd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface gbd_value_if
    import gbd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last_of_item;
    logic                  quotient_saturated;

    modport source (output valid, output value, output last_of_item,
                    output quotient_saturated, input ready);
    modport sink (input valid, input value, input last_of_item,
                  input quotient_saturated, output ready);
endinterface

@@ design/gbd_codeword.sv @@
module gbd_codeword
    import gbd_pkg::*;
#(
    parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF,
    parameter int DIVISOR_BITS  = DIVISOR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  gbd_cfg_wr_t cfg,
    input  logic        step,
    input  logic        bit_in,
    output gbd_result_t res
);

    localparam int RB   = $clog2(DIVISOR_BITS + 1);
    localparam int MW   = DIVISOR_BITS + 1;
    localparam int MAXD = 1 << DIVISOR_BITS;

    // derived divisor values, computed at write time
    logic [MW-1:0]           m_reg, m_next;
    logic [RB-1:0]           b_reg, b_next;
    logic [DIVISOR_BITS-1:0] u_reg, u_next;
    logic [MW-1:0]           m_minus1;

    logic                     phase_reg, phase_next;
    logic [QUOTIENT_BITS-1:0] q_reg, q_next;
    logic [VALUE_BITS-1:0]    acc_reg, acc_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [RB-1:0]            cnt_reg, cnt_next;
    logic                     sat_reg, sat_next;

    logic [DIVISOR_BITS-1:0]  rem_shift;
    logic [DIVISOR_BITS-1:0]  rem_out;
    logic [RB-1:0]            cnt_inc;

    always_comb
    begin
        if (cfg.data == '0)
        begin
            m_next = MW'(1);
        end
        else if (32'(cfg.data) > 32'(MAXD))
        begin
            m_next = MW'(MAXD);
        end
        else
        begin
            m_next = MW'(cfg.data);
        end
        m_minus1 = m_next - MW'(1);
        // ceil(log2 m) is the bit length of m - 1
        b_next = '0;
        for (int k = 0; k < DIVISOR_BITS; k++)
        begin
            if (m_minus1[k])
            begin
                b_next = RB'(k + 1);
            end
        end
        u_next = DIVISOR_BITS'((32'(1) << b_next) - 32'(m_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg <= MW'(1);
            b_reg <= '0;
            u_reg <= '0;
        end
        else if (cfg.we)
        begin
            m_reg <= m_next;
            b_reg <= b_next;
            u_reg <= u_next;
        end
    end

    assign rem_shift = DIVISOR_BITS'({rem_reg, bit_in});
    assign cnt_inc   = cnt_reg + RB'(1);

    always_comb
    begin
        phase_next = phase_reg;
        q_next     = q_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        res.emit   = 1'b0;
        rem_out    = '0;

        if (step)
        begin
            if (!phase_reg)
            begin
                if (bit_in)
                begin
                    if (q_reg == '1)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        q_next   = q_reg + QUOTIENT_BITS'(1);
                        // running product m * q
                        acc_next = acc_reg + VALUE_BITS'(m_reg);
                    end
                end
                else if (b_reg == '0)
                begin
                    res.emit = 1'b1;
                end
                else
                begin
                    phase_next = 1'b1;
                    rem_next   = '0;
                    cnt_next   = '0;
                end
            end
            else
            begin
                // short code word when the first b-1 bits fall below the threshold
                if (cnt_inc == b_reg - RB'(1) && rem_shift < u_reg)
                begin
                    res.emit = 1'b1;
                    rem_out  = rem_shift;
                end
                else if (cnt_inc >= b_reg)
                begin
                    res.emit = 1'b1;
                    rem_out  = rem_shift - u_reg;
                end
                else
                begin
                    rem_next = rem_shift;
                    cnt_next = cnt_inc;
                end
            end
        end

        res.value = acc_reg + VALUE_BITS'(rem_out);
        res.sat   = sat_reg;

        if (res.emit || cfg.we)
        begin
            phase_next = 1'b0;
            q_next     = '0;
            acc_next   = '0;
            rem_next   = '0;
            cnt_next   = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            q_reg     <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            q_reg     <= q_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

@@ design/golomb_bitstream_decoder_top.sv @@
// Golomb decoder with truncated binary remainder. Coded bytes enter on
// stream and are shifted out one bit per cycle, most significant first, into
// a bit-serial code word decoder, except while a held value waits for the
// output register or a byte's final value is flushed; the product divisor *
// quotient is built by adding the divisor once per unary one. A code word
// that ends on a byte's last bit is flushed with its last_of_item mark before
// the next bit is decoded. The next byte is taken in the cycle its
// predecessor's last bit is decoded. Results leave through an output
// register; a one-entry hold stage sits before it so that the final value of
// a byte can be marked. Write the divisor only while idle: a write restarts the code word in progress.
`include "golomb_bitstream_decoder_top_assert.svh"

module golomb_bitstream_decoder_top
    import gbd_pkg::*;
#(
    parameter int QUOTIENT_BITS = QUOTIENT_BITS_DEF,
    parameter int DIVISOR_BITS  = DIVISOR_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    gbd_byte_if.sink                    stream,
    gbd_value_if.source                 result,
    input  logic                        cfg_we,
    input  logic [DIVISOR_REG_BITS-1:0] cfg_wdata
);

    logic [BYTE_BITS-1:0]     sreg_reg, sreg_next;
    logic [BYTE_CNT_BITS-1:0] bits_left_reg, bits_left_next;

    logic                  hold_valid_reg, hold_valid_next;
    logic                  hold_final_reg, hold_final_next;
    logic [VALUE_BITS-1:0] hold_value_reg, hold_value_next;
    logic                  hold_sat_reg, hold_sat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_sat_reg, out_sat_next;

    gbd_cfg_wr_t cfg;
    gbd_result_t res;

    logic busy;
    logic last_bit;
    logic out_free;
    logic flush;
    logic step;
    logic push_mid;
    logic push_end;
    logic push;
    logic accept;

    assign cfg.we   = cfg_we;
    assign cfg.data = cfg_wdata;

    gbd_codeword #(
        .QUOTIENT_BITS (QUOTIENT_BITS),
        .DIVISOR_BITS  (DIVISOR_BITS)
    ) u_codeword (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .bit_in (sreg_reg[BYTE_BITS-1]),
        .res    (res)
    );

    assign busy     = bits_left_reg != '0;
    assign last_bit = bits_left_reg == BYTE_CNT_BITS'(1);
    assign out_free = !out_valid_reg || result.ready;
    // a held value that closed its byte goes out before anything else
    assign flush    = hold_valid_reg && hold_final_reg;
    assign step     = busy && !flush && (!hold_valid_reg || out_free);
    assign push_mid = step && hold_valid_reg && res.emit;
    assign push_end = (step && hold_valid_reg && !res.emit && last_bit) || (flush && out_free);
    assign push     = push_mid || push_end;

    assign stream.ready = !busy || (step && last_bit);
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        sreg_next      = sreg_reg;
        bits_left_next = bits_left_reg;
        if (accept)
        begin
            sreg_next      = stream.data_byte;
            bits_left_next = BYTE_CNT_BITS'(BYTE_BITS);
        end
        else if (step)
        begin
            sreg_next      = {sreg_reg[BYTE_BITS-2:0], 1'b0};
            bits_left_next = bits_left_reg - BYTE_CNT_BITS'(1);
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_final_next = hold_final_reg;
        hold_value_next = hold_value_reg;
        hold_sat_next   = hold_sat_reg;
        if (step && res.emit)
        begin
            hold_valid_next = 1'b1;
            hold_final_next = last_bit;
            hold_value_next = res.value;
            hold_sat_next   = res.sat;
        end
        else if (push_end)
        begin
            hold_valid_next = 1'b0;
            hold_final_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_sat_next   = out_sat_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_value_next = hold_value_reg;
            out_last_next  = push_end;
            out_sat_next   = hold_sat_reg;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_left_reg  <= '0;
            hold_valid_reg <= 1'b0;
            hold_final_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bits_left_reg  <= bits_left_next;
            hold_valid_reg <= hold_valid_next;
            hold_final_reg <= hold_final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg       <= sreg_next;
        hold_value_reg <= hold_value_next;
        hold_sat_reg   <= hold_sat_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_sat_reg    <= out_sat_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.value              = out_value_reg;
    assign result.last_of_item       = out_last_reg;
    assign result.quotient_saturated = out_sat_reg;

    `GBD_ASSERT_NOW(a_flush_blocks_step, clk, rst_n, flush, !step, "bit decoded during flush")
    `GBD_ASSERT_NOW(a_push_has_room, clk, rst_n, push, out_free, "beat pushed into full output")
    `GBD_ASSERT_NEXT(a_accept_loads_byte, clk, rst_n, accept, bits_left_reg == BYTE_CNT_BITS'(BYTE_BITS), "accepted byte not loaded")
    `GBD_ASSERT_NOW(a_final_needs_hold, clk, rst_n, hold_final_reg, hold_valid_reg, "final mark without held value")

endmodule

@@ tb/sv/golomb_bitstream_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module golomb_bitstream_decoder_top_tb
    import gbd_pkg::*;
();

    localparam int QBITS        = QUOTIENT_BITS_DEF;
    localparam int DBITS        = DIVISOR_BITS_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_LEN     = 400;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last_of_item;
        logic                  quotient_saturated;
    } codeword_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [DIVISOR_REG_BITS-1:0] cfg_wdata = '0;

    gbd_byte_if  stream_bus ();
    gbd_value_if result_bus ();

    golomb_bitstream_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // stimulus and prediction
    logic [7:0] coded_bytes[$];
    logic       code_bits[$];
    codeword_t  predicted_codewords[$];

    // decoder shadow state
    logic [DIVISOR_REG_BITS-1:0] div_reg = DIVISOR_REG_BITS'(1);
    logic                        in_rem = 1'b0;
    logic [QBITS-1:0]            q_count = '0;
    int unsigned                 r_accum = 0;
    int unsigned                 r_nbits = 0;
    logic                        q_sat = 1'b0;

    logic        byte_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    logic        send_gaps = 1'b1;
    logic        recv_stalls = 1'b1;
    logic        hold_armed = 1'b0;
    int unsigned hold_cycles = 0;
    logic        receiver_held;

    int unsigned cycle_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned values_checked = 0;
    int unsigned sat_seen = 0;
    int unsigned divisors_tried = 0;
    int unsigned mismatches = 0;

    assign receiver_held = hold_armed && (hold_cycles < HOLD_LEN);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void queue_byte(input logic [7:0] octet);
        coded_bytes.insert(coded_bytes.size(), octet);
    endfunction

    function automatic void queue_bit(input logic cbit);
        code_bits.insert(code_bits.size(), cbit);
    endfunction

    function automatic int unsigned eff_divisor(input logic [DIVISOR_REG_BITS-1:0] d);
        if (d == 0)
            return 1;
        if (d > (1 << DBITS))
            return 1 << DBITS;
        return 32'(d);
    endfunction

    function automatic int unsigned ceil_log2(input int unsigned m);
        int unsigned nb;
        nb = 0;
        while (nb < 31 && (32'd1 << nb) < m)
            nb++;
        return nb;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_codeword();
        in_rem  = 1'b0;
        q_count = '0;
        r_accum = 0;
        r_nbits = 0;
        q_sat   = 1'b0;
    endfunction

    function automatic void push_codeword(input int unsigned m, input int unsigned r);
        codeword_t   cw;
        longint unsigned v;
        v = longint'(m) * longint'(q_count) + longint'(r);
        cw.value              = v[VALUE_BITS-1:0];
        cw.last_of_item       = 1'b0;
        cw.quotient_saturated = q_sat;
        predicted_codewords.insert(predicted_codewords.size(), cw);
        clear_codeword();
    endfunction

    // walk the eight bits msb first, as the decoder does
    function automatic void golomb_decode_byte(input logic [7:0] octet);
        int unsigned m, nb, u;
        int          i, first_idx;
        logic        cbit;
        m         = eff_divisor(div_reg);
        nb        = ceil_log2(m);
        u         = (1 << nb) - m;
        first_idx = predicted_codewords.size();
        for (i = 7; i >= 0; i--)
        begin
            cbit = octet[i];
            if (!in_rem)
            begin
                if (cbit)
                begin
                    if (q_count == {QBITS{1'b1}})
                        q_sat = 1'b1;
                    else
                        q_count++;
                end
                else if (nb == 0)
                    push_codeword(m, 0);
                else
                begin
                    in_rem  = 1'b1;
                    r_accum = 0;
                    r_nbits = 0;
                end
            end
            else
            begin
                r_accum = ((r_accum << 1) | 32'(cbit)) & ((1 << DBITS) - 1);
                r_nbits++;
                if (r_nbits == nb - 1 && r_accum < u)
                    push_codeword(m, r_accum);
                else if (r_nbits >= nb)
                    push_codeword(m, r_accum - u);
            end
        end
        if (predicted_codewords.size() > first_idx)
            predicted_codewords[predicted_codewords.size()-1].last_of_item = 1'b1;
    endfunction

    task automatic add_codeword(input int unsigned m, input int unsigned q,
                                input int unsigned r);
        int unsigned nb, u, code, len;
        int          k;
        nb = ceil_log2(m);
        u  = (1 << nb) - m;
        repeat (q) queue_bit(1'b1);
        queue_bit(1'b0);
        if (nb != 0)
        begin
            // truncated binary: short form below the threshold
            if (r < u)
            begin
                code = r;
                len  = nb - 1;
            end
            else
            begin
                code = r + u;
                len  = nb;
            end
            for (k = int'(len) - 1; k >= 0; k--)
                queue_bit(code[k]);
        end
    endtask

    task automatic queue_coded_stream(input int unsigned m, input int nbytes,
                                      input bit noise_only);
        logic [7:0]  octet;
        int          n, k;
        int unsigned p, q;
        code_bits.delete();
        if (noise_only)
        begin
            repeat (nbytes) queue_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            while (code_bits.size() < 8 * nbytes)
            begin
                p = $urandom_range(0, 99);
                if (p < 10)
                begin
                    // broken codeword: a few loose bits
                    repeat ($urandom_range(1, 12)) queue_bit(1'($urandom_range(0, 1)));
                end
                else
                begin
                    if (p < 75)
                        q = $urandom_range(0, 3);
                    else if (p < 95)
                        q = $urandom_range(4, 20);
                    else
                        q = $urandom_range(21, 100);
                    add_codeword(m, q, $urandom_range(0, m - 1));
                end
            end
            // leftover bits are dropped, so a partial codeword stays pending
            for (n = 0; n < nbytes; n++)
            begin
                for (k = 7; k >= 0; k--)
                    octet[k] = code_bits.pop_front();
                queue_byte(octet);
            end
        end
    endtask

    task automatic write_divisor(input logic [DIVISOR_REG_BITS-1:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we    <= 1'b0;
        divisors_tried++;
    endtask

    task automatic wait_idle();
        while (coded_bytes.size() != 0 || stream_bus.valid || predicted_codewords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // accept side: shadow decoder follows register writes and taken beats
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
            div_reg = DIVISOR_REG_BITS'(1);
            clear_codeword();
        end
        else
        begin
            byte_taken <= stream_bus.valid && stream_bus.ready;
            if (cfg_we)
            begin
                div_reg = cfg_wdata;
                clear_codeword();
            end
            if (stream_bus.valid && stream_bus.ready)
            begin
                golomb_decode_byte(stream_bus.data_byte);
                bytes_accepted++;
            end
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stream_bus.valid     <= 1'b0;
            stream_bus.data_byte <= '0;
        end
        else if (!stream_bus.valid || byte_taken)
        begin
            if (gap_left != 0)
            begin
                stream_bus.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (coded_bytes.size() != 0)
            begin
                stream_bus.valid     <= 1'b1;
                stream_bus.data_byte <= coded_bytes.pop_front();
                gap_left <= send_gaps ? pick_gap() : 0;
            end
            else
                stream_bus.valid <= 1'b0;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (receiver_held)
            hold_cycles <= hold_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (stall_left != 0)
        begin
            result_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (receiver_held)
            result_bus.ready <= 1'b0;
        else if (recv_stalls && $urandom_range(0, 99) < 20)
        begin
            result_bus.ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            result_bus.ready <= 1'b1;
    end

    // value monitor
    always @(posedge clk)
    begin
        codeword_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (predicted_codewords.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected value %0d last %0b sat %0b, none predicted",
                             result_bus.value, result_bus.last_of_item,
                             result_bus.quotient_saturated);
                mismatches++;
            end
            else
            begin
                want = predicted_codewords.pop_front();
                if (result_bus.value !== want.value
                    || result_bus.last_of_item !== want.last_of_item
                    || result_bus.quotient_saturated !== want.quotient_saturated)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("value beat %0d: got %0d/%0b/%0b, expected %0d/%0b/%0b",
                                 values_checked, result_bus.value, result_bus.last_of_item,
                                 result_bus.quotient_saturated, want.value,
                                 want.last_of_item, want.quotient_saturated);
                    mismatches++;
                end
                values_checked++;
                if (result_bus.quotient_saturated)
                    sat_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d values still predicted",
                     cycle_count, predicted_codewords.size());
            $display("golomb_bitstream_decoder_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int unsigned divisor_list[16];
        int          ph, nbytes;
        logic [DIVISOR_REG_BITS-1:0] d;

        divisor_list = '{2, 5, 7, 12, 100, 255, 256, 1000,
                         2047, 4095, 4096, 5000, 8191, 0, 1, 3};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset divisor is one: every zero closes a codeword
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'hFE);
        queue_byte(8'h80);
        queue_byte(8'h55);
        wait_idle();

        // zero reads as one
        write_divisor(13'd0);
        queue_byte(8'hAA);
        queue_byte(8'h01);
        wait_idle();

        write_divisor(13'd3);
        queue_byte(8'h00);
        queue_byte(8'h5B);
        queue_byte(8'hFF);
        queue_byte(8'h3C);
        wait_idle();

        write_divisor(13'd4096);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'hBF);
        queue_byte(8'hFF);
        queue_byte(8'hE0);
        wait_idle();

        // above the top, clamps to 4096; leaves a partial codeword for the next write
        write_divisor(13'd8191);
        queue_byte(8'h41);
        queue_byte(8'h23);
        wait_idle();

        write_divisor(13'd2);
        queue_byte(8'hC9);
        wait_idle();

        write_divisor(13'd4095);
        queue_byte(8'h7F);
        queue_byte(8'hFF);
        queue_byte(8'h3E);
        wait_idle();

        for (ph = 0; ph < 20; ph++)
        begin
            if (ph < 16)
                d = DIVISOR_REG_BITS'(divisor_list[ph]);
            else
                d = DIVISOR_REG_BITS'($urandom_range(1, 8191));
            write_divisor(d);
            send_gaps   = (ph % 3 != 1);
            recv_stalls = (ph % 3 != 1);
            nbytes = int'($urandom_range(10, 26));
            if (ph == 4)
            begin
                // sender keeps offering while the receiver holds off
                send_gaps   = 1'b0;
                nbytes      = 40;
                hold_armed <= 1'b1;
            end
            queue_coded_stream(eff_divisor(d), nbytes, (ph % 4 == 3));
            wait_idle();
        end

        if (predicted_codewords.size() != 0)
        begin
            $display("%0d predicted values never arrived", predicted_codewords.size());
            mismatches++;
        end
        $display("covered %0d coded bytes over %0d divisor writes, %0d values checked",
                 bytes_accepted, divisors_tried, values_checked);
        $display("%0d saturated quotients, receiver hold-off of %0d cycles, %0d mismatches",
                 sat_seen, hold_cycles, mismatches);
        if (mismatches == 0)
            $display("golomb_bitstream_decoder_top_tb: done, clean");
        else
            $display("golomb_bitstream_decoder_top_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/gbd_pkg.sv
design/gbd_channels.sv
design/gbd_codeword.sv
design/golomb_bitstream_decoder_top.sv
tb/sv/golomb_bitstream_decoder_top_tb.sv
